[sv/loss_and_gradient_unit_top_macros.svh]
// Assertion macros shared by the loss and gradient unit RTL.
`ifndef LOSS_AND_GRADIENT_UNIT_TOP_MACROS_SVH
`define LOSS_AND_GRADIENT_UNIT_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LGU_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define LGU_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/lgu_pkg.sv]
// Shared constants, types, command codes and the logarithm table of the loss unit.
`timescale 1ns / 1ps
`default_nettype none
package lgu_pkg;

    localparam int FRAC_BITS      = 16;
    localparam int LOG_TABLE_BITS = 10;
    localparam int LOG_TABLE_SIZE = 1 << LOG_TABLE_BITS;
    localparam int Q30_BITS       = 30;
    localparam int LN_SHIFT       = Q30_BITS - FRAC_BITS;
    localparam logic [30:0] LN2_Q30 = 31'd744261118;

    // Clamped prediction width, msb position width, log magnitude widths.
    localparam int P_W   = FRAC_BITS;
    localparam int K_W   = $clog2(FRAC_BITS);
    localparam int M_W   = $clog2(FRAC_BITS + 1);
    localparam int MQ_W  = 31 + M_W;
    localparam int LN_W  = FRAC_BITS + 5;

    // Divider widths.
    localparam int DIV_W = 64;
    localparam int DVS_W = 24;
    localparam int CNT_W = $clog2(DIV_W + 1);

    localparam logic [47:0] LOSS_MAX = '1;

    typedef enum logic [1:0] {
        CFG_MODE,
        CFG_COLS,
        CFG_ELEMS,
        CFG_EPS
    } t_cfg_idx;

    typedef enum logic {
        MODE_MSE,
        MODE_BCE
    } t_mode;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_MUL_SQ,
        OP_SQ_TERM,
        OP_DIV_D,
        OP_SAVE_GRAD,
        OP_DIV_A,
        OP_SAVE_A,
        OP_DIV_B,
        OP_SAVE_B,
        OP_DIV_G,
        OP_IDX_P,
        OP_IDX_Q,
        OP_TBL,
        OP_LN_P,
        OP_LN_Q,
        OP_MUL_P,
        OP_SAVE_P,
        OP_MUL_Q,
        OP_TERM,
        OP_ADD_TERM,
        OP_DIV_L,
        OP_FIN
    } t_op;

    typedef enum logic [4:0] {
        S_IDLE,
        S_SQ_MUL,
        S_SQ_TERM,
        S_DIV_D,
        S_WAIT_D,
        S_DIV_A,
        S_WAIT_A,
        S_DIV_B,
        S_WAIT_B,
        S_DIV_G,
        S_WAIT_G,
        S_IDX_P,
        S_TBL_P,
        S_LN_P,
        S_IDX_Q,
        S_TBL_Q,
        S_LN_Q,
        S_MUL_P,
        S_SAVE_P,
        S_MUL_Q,
        S_TERM,
        S_ADD,
        S_DIV_L,
        S_WAIT_L,
        S_FIN
    } t_state;

    typedef struct packed {
        t_op op;
    } t_cmd;

    typedef struct packed {
        logic  div_done;
        logic  out_full;
        logic  last;
        logic  col_zero;
        t_mode mode;
    } t_status;

    typedef logic [30:0] t_ln_table [LOG_TABLE_SIZE];

    // Unsigned shift-and-subtract division, used only while building constants.
    function automatic longint unsigned const_udiv(longint unsigned num,
                                                   longint unsigned den);
        longint unsigned quo;
        longint unsigned rem;
        quo = '0;
        rem = '0;
        for (int i = 63; i >= 0; i--) begin
            rem = {rem[62:0], num[i]};
            if (rem >= den) begin
                rem    = rem - den;
                quo[i] = 1'b1;
            end
        end
        return quo;
    endfunction

    // ln(1 + i/2^LOG_TABLE_BITS) in Q30 by an integer atanh series.
    function automatic t_ln_table build_ln_table();
        t_ln_table       tbl;
        longint unsigned u;
        longint unsigned z;
        longint unsigned z2;
        longint unsigned pw;
        longint unsigned acc;
        longint unsigned n;
        bit              stop;
        for (int i = 0; i < LOG_TABLE_SIZE; i++) begin
            u    = longint'(i) << (Q30_BITS - LOG_TABLE_BITS);
            z    = const_udiv(u << Q30_BITS, (64'd1 << (Q30_BITS + 1)) + u);
            z2   = (z * z) >> Q30_BITS;
            pw   = z;
            acc  = z;
            stop = 1'b0;
            for (n = 3; n < 129; n += 2) begin
                if (!stop) begin
                    pw = (pw * z2) >> Q30_BITS;
                    if (pw == 0) begin
                        stop = 1'b1;
                    end else begin
                        acc += const_udiv(pw, n);
                    end
                end
            end
            tbl[i] = 31'(2 * acc);
        end
        return tbl;
    endfunction

    localparam t_ln_table LN_TABLE = build_ln_table();

endpackage
`default_nettype wire

[sv/lgu_div.sv]
// Radix-2 restoring divider, signed dividend over positive divisor, truncating.
`timescale 1ns / 1ps
`default_nettype none
`include "loss_and_gradient_unit_top_macros.svh"
module lgu_div (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_start,
    input  wire logic signed [63:0]         i_dividend,
    input  wire logic [lgu_pkg::DVS_W-1:0]  i_divisor,
    output logic                            o_done,
    output logic signed [63:0]              o_quotient
);
    import lgu_pkg::*;

    logic                r_busy;
    logic                r_done;
    logic [CNT_W-1:0]    r_cnt;
    logic                r_neg;
    logic [DIV_W-1:0]    r_quo;
    logic [DVS_W:0]      r_rem;
    logic [DVS_W-1:0]    r_dvs;
    logic [DIV_W-1:0]    n_quo;
    logic [DVS_W:0]      n_rem;
    logic [DVS_W:0]      shifted;
    logic [DVS_W+1:0]    diff;
    logic [DIV_W-1:0]    dividend_mag;

    // Magnitude of the dividend; the sign is applied back at the end.
    assign dividend_mag = i_dividend[63] ? DIV_W'(-i_dividend) : DIV_W'(i_dividend);

    // One quotient bit per cycle.
    always_comb begin
        shifted = {r_rem[DVS_W-1:0], r_quo[DIV_W-1]};
        diff    = {1'b0, shifted} - {2'b00, r_dvs};
        if (!diff[DVS_W+1]) begin
            n_rem = diff[DVS_W:0];
            n_quo = {r_quo[DIV_W-2:0], 1'b1};
        end else begin
            n_rem = shifted;
            n_quo = {r_quo[DIV_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DIV_W);
                r_neg  <= i_dividend[63];
                r_quo  <= dividend_mag;
                r_rem  <= '0;
                r_dvs  <= i_divisor;
            end else if (r_busy) begin
                r_rem <= n_rem;
                r_quo <= n_quo;
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_neg ? -$signed(r_quo) : $signed(r_quo);

    `LGU_ASSERT_NEXT(a_start_busy, i_clk, i_rst_n, i_start, r_busy, "divider did not start")
    `LGU_ASSERT_SAME(a_done_idle, i_clk, i_rst_n, r_done, !r_busy, "divider done while busy")

endmodule
`default_nettype wire

[sv/lgu_ctrl.sv]
// Sequencer that steps the loss datapath through one element.
`timescale 1ns / 1ps
`default_nettype none
module lgu_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    output logic                  o_ready,
    input  wire lgu_pkg::t_status i_status,
    output lgu_pkg::t_cmd         o_cmd
);
    import lgu_pkg::*;

    t_state r_state;
    t_state n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and datapath command.
    always_comb begin
        n_state  = r_state;
        o_cmd.op = OP_NONE;
        o_ready  = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.op = OP_LOAD;
                    if (i_status.mode == MODE_BCE) begin
                        n_state = S_DIV_A;
                    end else if (i_status.col_zero) begin
                        n_state = S_FIN;
                    end else begin
                        n_state = S_SQ_MUL;
                    end
                end
            end
            S_SQ_MUL: begin
                o_cmd.op = OP_MUL_SQ;
                n_state  = S_SQ_TERM;
            end
            S_SQ_TERM: begin
                o_cmd.op = OP_SQ_TERM;
                n_state  = S_DIV_D;
            end
            S_DIV_D: begin
                o_cmd.op = OP_DIV_D;
                n_state  = S_WAIT_D;
            end
            S_WAIT_D: begin
                if (i_status.div_done) begin
                    o_cmd.op = OP_SAVE_GRAD;
                    n_state  = S_ADD;
                end
            end
            S_DIV_A: begin
                o_cmd.op = OP_DIV_A;
                n_state  = S_WAIT_A;
            end
            S_WAIT_A: begin
                if (i_status.div_done) begin
                    o_cmd.op = OP_SAVE_A;
                    n_state  = S_DIV_B;
                end
            end
            S_DIV_B: begin
                o_cmd.op = OP_DIV_B;
                n_state  = S_WAIT_B;
            end
            S_WAIT_B: begin
                if (i_status.div_done) begin
                    o_cmd.op = OP_SAVE_B;
                    n_state  = S_DIV_G;
                end
            end
            S_DIV_G: begin
                o_cmd.op = OP_DIV_G;
                n_state  = S_WAIT_G;
            end
            S_WAIT_G: begin
                if (i_status.div_done) begin
                    o_cmd.op = OP_SAVE_GRAD;
                    n_state  = S_IDX_P;
                end
            end
            S_IDX_P: begin
                o_cmd.op = OP_IDX_P;
                n_state  = S_TBL_P;
            end
            S_TBL_P: begin
                o_cmd.op = OP_TBL;
                n_state  = S_LN_P;
            end
            S_LN_P: begin
                o_cmd.op = OP_LN_P;
                n_state  = S_IDX_Q;
            end
            S_IDX_Q: begin
                o_cmd.op = OP_IDX_Q;
                n_state  = S_TBL_Q;
            end
            S_TBL_Q: begin
                o_cmd.op = OP_TBL;
                n_state  = S_LN_Q;
            end
            S_LN_Q: begin
                o_cmd.op = OP_LN_Q;
                n_state  = S_MUL_P;
            end
            S_MUL_P: begin
                o_cmd.op = OP_MUL_P;
                n_state  = S_SAVE_P;
            end
            S_SAVE_P: begin
                o_cmd.op = OP_SAVE_P;
                n_state  = S_MUL_Q;
            end
            S_MUL_Q: begin
                o_cmd.op = OP_MUL_Q;
                n_state  = S_TERM;
            end
            S_TERM: begin
                o_cmd.op = OP_TERM;
                n_state  = S_ADD;
            end
            S_ADD: begin
                o_cmd.op = OP_ADD_TERM;
                n_state  = i_status.last ? S_DIV_L : S_FIN;
            end
            S_DIV_L: begin
                o_cmd.op = OP_DIV_L;
                n_state  = S_WAIT_L;
            end
            S_WAIT_L: begin
                if (i_status.div_done) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (!i_status.out_full) begin
                    o_cmd.op = OP_FIN;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

[sv/lgu_dp.sv]
// Datapath: configuration, operand registers, multiplier, divider, log lookup, loss sum.
`timescale 1ns / 1ps
`default_nettype none
`include "loss_and_gradient_unit_top_macros.svh"
module lgu_dp (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_cfg_we,
    input  wire lgu_pkg::t_cfg_idx   i_cfg_idx,
    input  wire logic [23:0]         i_cfg_data,
    input  wire logic signed [31:0]  i_predicted,
    input  wire logic signed [31:0]  i_target_value,
    input  wire logic                i_last_element,
    input  wire lgu_pkg::t_cmd       i_cmd,
    output lgu_pkg::t_status         o_status,
    output logic                     o_valid,
    input  wire logic                i_ready,
    output logic signed [31:0]       o_gradient,
    output logic [47:0]              o_loss_value,
    output logic                     o_loss_valid,
    output logic                     o_error_flag
);
    import lgu_pkg::*;

    localparam logic [31:0] ONE_32  = 32'(1) << FRAC_BITS;
    localparam logic [31:0] HALF_32 = 32'(1) << (FRAC_BITS - 1);
    localparam logic [32:0] ONE_33  = 33'(1) << FRAC_BITS;
    localparam logic signed [63:0] ROUND_64 = 64'((64'(1) << FRAC_BITS) - 1);

    // Configuration registers.
    t_mode              r_mode;
    logic [15:0]        r_cols;
    logic [23:0]        r_elems;
    logic [14:0]        r_eps;

    // Item registers.
    logic [P_W-1:0]     r_p;
    logic [P_W-1:0]     r_q;
    logic signed [31:0] r_y;
    logic signed [32:0] r_d;
    logic               r_last;
    logic               r_err;
    logic [DVS_W-1:0]   r_dvs;

    // Working registers.
    logic signed [63:0] r_prod;
    logic signed [63:0] r_acc;
    logic signed [63:0] r_term;
    logic signed [63:0] r_sum;
    logic signed [63:0] r_a;
    logic signed [63:0] r_b;
    logic signed [31:0] r_grad;
    logic [K_W-1:0]     r_k;
    logic [LOG_TABLE_BITS-1:0] r_idx;
    logic [30:0]        r_tbl;
    logic signed [LN_W:0] r_lp;
    logic signed [LN_W:0] r_lq;

    // Result register.
    logic               r_out_valid;
    logic signed [31:0] r_out_grad;
    logic [47:0]        r_out_loss;
    logic               r_out_last;
    logic               r_out_err;

    // Combinational nets.
    logic [31:0]        eps_eff;
    logic [P_W-1:0]     p_clamp;
    logic signed [32:0] omy;
    logic [32:0]        d_mag;
    logic signed [33:0] mul_a;
    logic signed [33:0] mul_b;
    logic signed [67:0] mul_p;
    logic               div_start;
    logic signed [63:0] div_dividend;
    logic [DVS_W-1:0]   div_divisor;
    logic               div_done;
    logic signed [63:0] div_quot;
    logic signed [31:0] grad_sat;
    logic [47:0]        loss_clamp;
    logic [P_W-1:0]     log_x;
    logic [K_W-1:0]     log_k;
    logic [P_W-1:0]     log_norm;
    logic [P_W-2+LOG_TABLE_BITS:0] log_ext;
    logic [M_W-1:0]     ln_m;
    logic [MQ_W-1:0]    ln_diff;
    logic [MQ_W-1:0]    ln_mag;
    logic signed [LN_W:0] ln_val;
    logic signed [63:0] ce_acc;
    logic signed [63:0] ce_div;
    logic signed [64:0] sum_wide;
    logic signed [63:0] sum_sat;

    // Clamp margin and the clamped prediction.
    always_comb begin
        eps_eff = (r_eps == '0) ? 32'd1 : 32'(r_eps);
        if (eps_eff > HALF_32) begin
            eps_eff = HALF_32;
        end
        if (i_predicted < $signed(eps_eff)) begin
            p_clamp = P_W'(eps_eff);
        end else if (i_predicted > $signed(ONE_32 - eps_eff)) begin
            p_clamp = P_W'(ONE_32 - eps_eff);
        end else begin
            p_clamp = P_W'(i_predicted);
        end
    end

    assign omy   = $signed(ONE_33) - $signed({r_y[31], r_y});
    assign d_mag = r_d[32] ? 33'(-r_d) : 33'(r_d);

    // Shared multiplier operand selection.
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (i_cmd.op)
            OP_MUL_SQ: begin
                mul_a = $signed({1'b0, d_mag});
                mul_b = $signed({1'b0, d_mag});
            end
            OP_MUL_P: begin
                mul_a = 34'(r_y);
                mul_b = 34'(r_lp);
            end
            OP_MUL_Q: begin
                mul_a = 34'(omy);
                mul_b = 34'(r_lq);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // Divider request selection.
    always_comb begin
        div_start    = 1'b0;
        div_dividend = '0;
        div_divisor  = r_dvs;
        case (i_cmd.op)
            OP_DIV_D: begin
                div_start    = 1'b1;
                div_dividend = 64'(r_d);
            end
            OP_DIV_A: begin
                div_start    = 1'b1;
                div_dividend = 64'(omy) <<< FRAC_BITS;
                div_divisor  = DVS_W'(r_q);
            end
            OP_DIV_B: begin
                div_start    = 1'b1;
                div_dividend = 64'(r_y) <<< FRAC_BITS;
                div_divisor  = DVS_W'(r_p);
            end
            OP_DIV_G: begin
                div_start    = 1'b1;
                div_dividend = r_a - r_b;
            end
            OP_DIV_L: begin
                div_start    = 1'b1;
                div_dividend = r_sum;
            end
            default: begin
                div_start = 1'b0;
            end
        endcase
    end

    lgu_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_quotient (div_quot)
    );

    // Saturation of the quotient to the gradient and loss ranges.
    always_comb begin
        if (!div_quot[63] && (|div_quot[62:31])) begin
            grad_sat = 32'sh7FFF_FFFF;
        end else if (div_quot[63] && !(&div_quot[62:31])) begin
            grad_sat = 32'sh8000_0000;
        end else begin
            grad_sat = div_quot[31:0];
        end
        if (div_quot[63]) begin
            loss_clamp = '0;
        end else if (|div_quot[62:48]) begin
            loss_clamp = LOSS_MAX;
        end else begin
            loss_clamp = div_quot[47:0];
        end
    end

    // Log table index: msb position and the bits right under it.
    always_comb begin
        log_x = (i_cmd.op == OP_IDX_Q) ? r_q : r_p;
        log_k = '0;
        for (int b = 0; b < P_W; b++) begin
            if (log_x[b]) begin
                log_k = K_W'(b);
            end
        end
        log_norm = log_x << (K_W'(P_W - 1) - log_k);
        log_ext  = {log_norm[P_W-2:0], {LOG_TABLE_BITS{1'b0}}};
    end

    // ln(x) = (k - FRAC_BITS)*ln2 + T[idx], scaled down and truncated toward zero.
    always_comb begin
        ln_m    = M_W'(FRAC_BITS) - M_W'(r_k);
        ln_diff = MQ_W'(ln_m) * MQ_W'(LN2_Q30) - MQ_W'(r_tbl);
        ln_mag  = ln_diff >> LN_SHIFT;
        ln_val  = -$signed({1'b0, ln_mag[LN_W-1:0]});
    end

    // Cross entropy term -(acc / ONE), truncated toward zero.
    always_comb begin
        ce_acc = r_acc + r_prod;
        if (ce_acc[63]) begin
            ce_div = (ce_acc + ROUND_64) >>> FRAC_BITS;
        end else begin
            ce_div = ce_acc >>> FRAC_BITS;
        end
    end

    // Saturating accumulation of the loss sum.
    always_comb begin
        sum_wide = {r_sum[63], r_sum} + {r_term[63], r_term};
        if (sum_wide[64] != sum_wide[63]) begin
            sum_sat = sum_wide[64] ? 64'sh8000_0000_0000_0000 : 64'sh7FFF_FFFF_FFFF_FFFF;
        end else begin
            sum_sat = sum_wide[63:0];
        end
    end

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_MSE;
            r_cols  <= 16'd1;
            r_elems <= 24'd1;
            r_eps   <= 15'd1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_MODE:  r_mode  <= t_mode'(i_cfg_data[0]);
                CFG_COLS:  r_cols  <= i_cfg_data[15:0];
                CFG_ELEMS: r_elems <= i_cfg_data;
                CFG_EPS:   r_eps   <= i_cfg_data[14:0];
                default:   r_mode  <= r_mode;
            endcase
        end
    end

    // Operand and working registers.
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_LOAD: begin
                r_p    <= p_clamp;
                r_q    <= P_W'(ONE_32 - 32'(p_clamp));
                r_y    <= i_target_value;
                r_d    <= {i_predicted[31], i_predicted} - {i_target_value[31], i_target_value};
                r_last <= i_last_element;
                r_err  <= (r_mode == MODE_MSE) && (r_cols == '0);
                r_grad <= '0;
                if (r_mode == MODE_BCE) begin
                    r_dvs <= (r_elems == '0) ? DVS_W'(1) : r_elems;
                end else begin
                    r_dvs <= DVS_W'(r_cols);
                end
            end
            OP_MUL_SQ, OP_MUL_P, OP_MUL_Q: r_prod <= mul_p[63:0];
            OP_SQ_TERM:   r_term <= $signed(64'($unsigned(r_prod) >> FRAC_BITS));
            OP_SAVE_GRAD: r_grad <= grad_sat;
            OP_SAVE_A:    r_a    <= div_quot;
            OP_SAVE_B:    r_b    <= div_quot;
            OP_IDX_P, OP_IDX_Q: begin
                r_k   <= log_k;
                r_idx <= log_ext[P_W-2+LOG_TABLE_BITS -: LOG_TABLE_BITS];
            end
            OP_TBL:       r_tbl  <= LN_TABLE[r_idx];
            OP_LN_P:      r_lp   <= ln_val;
            OP_LN_Q:      r_lq   <= ln_val;
            OP_SAVE_P:    r_acc  <= r_prod;
            OP_TERM:      r_term <= -ce_div;
            default:      r_k    <= r_k;
        endcase
    end

    // Loss sum and the result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cmd.op == OP_ADD_TERM) begin
                r_sum <= sum_sat;
            end
            if (i_cmd.op == OP_FIN) begin
                r_out_valid <= 1'b1;
                r_out_grad  <= r_grad;
                r_out_loss  <= (r_last && !r_err) ? loss_clamp : '0;
                r_out_last  <= r_last;
                r_out_err   <= r_err;
                if (r_last) begin
                    r_sum <= '0;
                end
            end
        end
    end

    assign o_status.div_done = div_done;
    assign o_status.out_full = r_out_valid;
    assign o_status.last     = r_last;
    assign o_status.col_zero = (r_cols == '0);
    assign o_status.mode     = r_mode;

    assign o_valid      = r_out_valid;
    assign o_gradient   = r_out_grad;
    assign o_loss_value = r_out_loss;
    assign o_loss_valid = r_out_last;
    assign o_error_flag = r_out_err;

    `LGU_ASSERT_SAME(a_fin_free, i_clk, i_rst_n, i_cmd.op == OP_FIN, !r_out_valid, "result overwritten")
    `LGU_ASSERT_NEXT(a_fin_valid, i_clk, i_rst_n, i_cmd.op == OP_FIN, r_out_valid, "result not shown")
    `LGU_ASSERT_NEXT(a_sum_clear, i_clk, i_rst_n, (i_cmd.op == OP_FIN) && r_last, r_sum == '0, "sum not cleared")

endmodule
`default_nettype wire

[sv/loss_and_gradient_unit_top.sv]
// Top level of the loss and gradient unit: sequencer and datapath.
`timescale 1ns / 1ps
`default_nettype none
// Takes prediction/target pairs in signed Q16.16 and returns one saturated
// gradient per pair; on the element marked last it also returns the averaged
// loss (Q32.16) and clears the running sum. Mode 0 is mean squared error over
// column_count, mode 1 is binary cross entropy over element_count. One element
// is in work at a time. The shared divider makes one quotient bit per cycle;
// a mean squared error element takes one division, a cross entropy element
// three, and the last element one more for the average; with a zero column
// count in mean squared error mode an element takes no division. A finished
// result waits in an output register while the next request is taken; a
// result that is still waiting there holds the unit before its next result is
// written. Configuration is written through a plain write port; the user must
// write it only while the unit is idle; the block does not enforce this.
module loss_and_gradient_unit_top (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_ready,
    input  wire logic signed [31:0] i_predicted,
    input  wire logic signed [31:0] i_target_value,
    input  wire logic               i_last_element,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output logic signed [31:0]      o_gradient,
    output logic [47:0]             o_loss_value,
    output logic                    o_loss_valid,
    output logic                    o_error_flag,
    input  wire logic               i_cfg_we,
    input  wire logic [1:0]         i_cfg_idx,
    input  wire logic [23:0]        i_cfg_data
);
    import lgu_pkg::*;

    t_cmd    cmd;
    t_status status;

    // Sequencer.
    lgu_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .i_status (status),
        .o_cmd    (cmd)
    );

    // Datapath.
    lgu_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (t_cfg_idx'(i_cfg_idx)),
        .i_cfg_data     (i_cfg_data),
        .i_predicted    (i_predicted),
        .i_target_value (i_target_value),
        .i_last_element (i_last_element),
        .i_cmd          (cmd),
        .o_status       (status),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_gradient     (o_gradient),
        .o_loss_value   (o_loss_value),
        .o_loss_valid   (o_loss_valid),
        .o_error_flag   (o_error_flag)
    );

endmodule
`default_nettype wire

[tb/tb_top.sv]
// Self-checking testbench for the loss and gradient unit.
`timescale 1ns / 1ps
`default_nettype none
module tb_top;
    import lgu_pkg::*;

    localparam longint ONE_Q = 64'sd1 << 16;

    typedef struct {
        logic signed [31:0] gradient;
        logic [47:0]        loss_value;
        logic               loss_valid;
        logic               error_flag;
    } t_grad_result;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_ready;
    logic signed [31:0] i_predicted = '0;
    logic signed [31:0] i_target_value = '0;
    logic               i_last_element = 1'b0;
    logic               o_valid;
    logic               i_ready = 1'b0;
    logic signed [31:0] o_gradient;
    logic [47:0]        o_loss_value;
    logic               o_loss_valid;
    logic               o_error_flag;
    logic               i_cfg_we = 1'b0;
    logic [1:0]         i_cfg_idx = '0;
    logic [23:0]        i_cfg_data = '0;

    // Mirror of the unit's configuration and running sum.
    t_mode          cur_mode = MODE_MSE;
    logic [15:0]    cur_cols = 16'd1;
    logic [23:0]    cur_elems = 24'd1;
    logic [14:0]    cur_eps = 15'd1;
    longint         loss_acc = 0;
    longint         ln_frac_tbl [1024];
    t_grad_result   grad_expect_q [$];
    int             fail_count = 0;
    bit             calm = 1'b0;
    int             stall_left = 0;

    loss_and_gradient_unit_top u_dut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        #40_000_000;
        $display("tb: failure");
        $finish;
    end

    // Build ln(1 + i/1024) in Q30 with the atanh series.
    task automatic make_ln_table();
        longint unsigned u, z, z2, pw, acc;
        for (int i = 0; i < 1024; i++) begin
            u   = longint'(i) << 20;
            z   = (u << 30) / ((64'd1 << 31) + u);
            z2  = (z * z) >> 30;
            pw  = z;
            acc = z;
            for (int n = 3; n < 129; n += 2) begin
                pw = (pw * z2) >> 30;
                if (pw == 0) break;
                acc += pw / n;
            end
            ln_frac_tbl[i] = longint'(2 * acc);
        end
    endtask

    function automatic longint clip32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint add_sat64(longint a, longint b);
        longint s;
        s = a + b;
        if (b > 0 && s < a) return 64'h7FFF_FFFF_FFFF_FFFF;
        if (b < 0 && s > a) return 64'h8000_0000_0000_0000;
        return s;
    endfunction

    // Natural log of x/2^16 in Q16.16, table based.
    function automatic longint ln_q16(longint x);
        int     k;
        longint rem, idx, q30;
        k = 0;
        for (int b = 0; b < 32; b++) if (x[b]) k = b;
        rem = x - (64'sd1 << k);
        idx = (k >= 10) ? (rem >>> (k - 10)) : (rem <<< (10 - k));
        idx = idx & 1023;
        q30 = longint'(k - 16) * 64'sd744261118 + ln_frac_tbl[idx];
        return q30 / (64'sd1 << 14);
    endfunction

    // Expected result of one element; updates the running loss sum.
    function automatic t_grad_result predict_element(logic signed [31:0] pv,
                                                     logic signed [31:0] yv,
                                                     logic last);
        t_grad_result r;
        longint p, y, d, div, eps, q, a, bt, acc, avg;
        longint unsigned mag;
        p = pv;
        y = yv;
        r.gradient = '0;
        r.error_flag = 1'b0;
        r.loss_value = '0;
        r.loss_valid = last;
        if (cur_mode == MODE_MSE) begin
            div = cur_cols;
            if (cur_cols == 0) begin
                r.error_flag = 1'b1;
            end else begin
                d = p - y;
                mag = (d < 0) ? longint'(-d) : d;
                r.gradient = clip32(d / div);
                loss_acc = add_sat64(loss_acc, longint'((mag * mag) >> 16));
            end
        end else begin
            div = (cur_elems == 0) ? 1 : cur_elems;
            eps = cur_eps;
            if (eps < 1) eps = 1;
            if (eps > ONE_Q / 2) eps = ONE_Q / 2;
            if (p < eps) p = eps;
            else if (p > ONE_Q - eps) p = ONE_Q - eps;
            q = ONE_Q - p;
            a = ((ONE_Q - y) * ONE_Q) / q;
            bt = (y * ONE_Q) / p;
            r.gradient = clip32((a - bt) / div);
            acc = y * ln_q16(p) + (ONE_Q - y) * ln_q16(q);
            loss_acc = add_sat64(loss_acc, -(acc / ONE_Q));
        end
        if (last) begin
            if (div > 0) begin
                avg = loss_acc / div;
                if (avg < 0) avg = 0;
                r.loss_value = (avg > 64'sh0000_FFFF_FFFF_FFFF) ? LOSS_MAX : avg[47:0];
            end
            loss_acc = 0;
        end
        return r;
    endfunction

    // Receiver back-pressure in short random bursts.
    always @(negedge i_clk) begin
        if (calm) begin
            i_ready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            i_ready <= 1'b0;
        end else if ($urandom_range(0, 5) == 0) begin
            stall_left <= $urandom_range(0, 3);
            i_ready <= 1'b0;
        end else begin
            i_ready <= 1'b1;
        end
    end

    // Compare each returned result with the oldest expectation.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (grad_expect_q.size() == 0) begin
                $display("%0t: result with nothing expected: grad %0d", $time, o_gradient);
                fail_count++;
            end else begin
                automatic t_grad_result e = grad_expect_q.pop_front();
                if (o_gradient !== e.gradient) begin
                    $display("%0t: gradient expected %0d actual %0d",
                             $time, e.gradient, o_gradient);
                    fail_count++;
                end
                if (o_loss_value !== e.loss_value) begin
                    $display("%0t: loss_value expected %0d actual %0d",
                             $time, e.loss_value, o_loss_value);
                    fail_count++;
                end
                if (o_loss_valid !== e.loss_valid) begin
                    $display("%0t: loss_valid expected %0b actual %0b",
                             $time, e.loss_valid, o_loss_valid);
                    fail_count++;
                end
                if (o_error_flag !== e.error_flag) begin
                    $display("%0t: error_flag expected %0b actual %0b",
                             $time, e.error_flag, o_error_flag);
                    fail_count++;
                end
            end
        end
    end

    // Send one request; called at a falling edge and returns at one.
    task automatic send_element(logic signed [31:0] pv, logic signed [31:0] yv, logic last);
        if (!calm && $urandom_range(0, 3) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge i_clk);
        end
        i_valid        <= 1'b1;
        i_predicted    <= pv;
        i_target_value <= yv;
        i_last_element <= last;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        grad_expect_q.push_back(predict_element(pv, yv, last));
        @(negedge i_clk);
    endtask

    // Let the unit drain completely.
    task automatic wait_drained();
        i_valid <= 1'b0;
        @(negedge i_clk);
        while (grad_expect_q.size() != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
    endtask

    // Write one register; the unit must be drained.
    task automatic write_reg(t_cfg_idx idx, logic [23:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        case (idx)
            CFG_MODE:  cur_mode  = t_mode'(val[0]);
            CFG_COLS:  cur_cols  = val[15:0];
            CFG_ELEMS: cur_elems = val;
            default:   cur_eps   = val[14:0];
        endcase
        @(negedge i_clk);
    endtask

    task automatic set_config(t_mode m, logic [15:0] c, logic [23:0] n, logic [14:0] e);
        wait_drained();
        write_reg(CFG_MODE, 24'(m));
        write_reg(CFG_COLS, 24'(c));
        write_reg(CFG_ELEMS, n);
        write_reg(CFG_EPS, 24'(e));
    endtask

    function automatic logic signed [31:0] rand_value(bit near_unit);
        if (near_unit && $urandom_range(0, 9) < 7) return $urandom_range(0, 65536);
        case ($urandom_range(0, 5))
            0:       return 32'sh7FFF_FFFF;
            1:       return 32'sh8000_0000;
            2:       return $signed($urandom_range(0, 1 << 20)) - (1 << 19);
            default: return $urandom;
        endcase
    endfunction

    // Reset defaults, field extremes and zero column count in squared error.
    task automatic test_mse_directed();
        send_element(32'sd65536, 32'sd0, 1'b0);
        send_element(32'sh7FFF_FFFF, 32'sh8000_0000, 1'b0);
        send_element(32'sh8000_0000, 32'sh7FFF_FFFF, 1'b1);
        set_config(MODE_MSE, 16'd3, 24'd5, 15'd100);
        send_element(-32'sd7, 32'sd0, 1'b0);
        send_element(32'sd123456, -32'sd98765, 1'b1);
        set_config(MODE_MSE, 16'd0, 24'd1, 15'd1);
        send_element(32'sd1000, 32'sd5, 1'b0);
        send_element(32'sd1000, 32'sd5, 1'b1);
        set_config(MODE_MSE, 16'hFFFF, 24'd1, 15'd1);
        send_element(32'sh7FFF_FFFF, 32'sh8000_0000, 1'b1);
    endtask

    // Cross entropy: clamping, targets out of range, epsilon and count extremes.
    task automatic test_bce_directed();
        set_config(MODE_BCE, 16'd1, 24'd0, 15'd0);
        send_element(32'sd0, 32'sd65536, 1'b0);
        send_element(32'sd65536, 32'sd0, 1'b0);
        send_element(32'sh8000_0000, 32'sd32768, 1'b1);
        set_config(MODE_BCE, 16'd1, 24'hFF_FFFF, 15'h7FFF);
        send_element(32'sh7FFF_FFFF, 32'sd20000, 1'b0);
        send_element(32'sd40000, 32'sh7FFF_FFFF, 1'b1);
        set_config(MODE_BCE, 16'd1, 24'd4, 15'd655);
        send_element(32'sd30000, -32'sd70000, 1'b0);
        send_element(32'sd1, 32'sh8000_0000, 1'b0);
        send_element(32'sd65535, 32'sd65536, 1'b1);
    endtask

    // Random phases under random settings, the extremes among them.
    task automatic test_random_phases();
        logic [15:0] cols_pick [5] = '{16'd0, 16'd1, 16'hFFFF, 16'd2, 16'd16};
        logic [23:0] elems_pick [5] = '{24'd0, 24'd1, 24'hFF_FFFF, 24'd3, 24'd64};
        logic [14:0] eps_pick [5] = '{15'd0, 15'd1, 15'h7FFF, 15'd64, 15'd3000};
        t_mode       m;
        for (int ph = 0; ph < 9; ph++) begin
            m = t_mode'(ph % 2);
            calm = (ph == 8);
            set_config(m,
                       ($urandom_range(0, 2) == 0) ? 16'($urandom) : cols_pick[$urandom_range(0, 4)],
                       ($urandom_range(0, 2) == 0) ? 24'($urandom) : elems_pick[$urandom_range(0, 4)],
                       ($urandom_range(0, 2) == 0) ? 15'($urandom) : eps_pick[$urandom_range(0, 4)]);
            for (int n = 0; n < 200; n++) begin
                send_element(rand_value(m == MODE_BCE), rand_value(m == MODE_BCE),
                             $urandom_range(0, 7) == 0);
                // Hold the sender off once until everything has come back.
                if (ph == 2 && n == 100) wait_drained();
            end
        end
    endtask

    initial begin
        make_ln_table();
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_mse_directed();
        test_bce_directed();
        test_random_phases();
        i_valid <= 1'b0;
        while (grad_expect_q.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
`default_nettype wire
